[src/estc_pkg.sv]
// ---------------------------------------------------------------------------
// estc_pkg
// shared widths and constants for the epoch seconds to calendar converter
// ---------------------------------------------------------------------------
package estc_pkg;

  localparam int SEC_W   = 32;
  localparam int DAYS_W  = 15;   // days below 2^31 / 86400
  localparam int REM_W   = 17;   // seconds within a day
  localparam int RS_W    = 12;   // seconds within an hour
  localparam int DOY_W   = 9;
  localparam int YIDX_W  = 7;
  localparam int YEAR_W  = 11;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SECF_W  = 6;

  // years that fit in 2^31 seconds, counting the partial one
  localparam int NUM_YEARS = 69;

  localparam logic [SEC_W-1:0] MAX_VALID_COUNT = 32'h7FFF_FFFF;
  localparam logic [REM_W-1:0] SECS_PER_DAY    = 17'd86400;
  localparam logic [RS_W-1:0]  SECS_PER_HOUR   = 12'd3600;
  localparam logic [SECF_W:0]  SECS_PER_MIN    = 7'd60;

  // reciprocals: 86400 = 128*675, 3600 = 16*225, 60 = 4*15
  localparam logic [24:0] RECIP_DAY  = 25'd25451659;  // 2^34 / 675
  localparam logic [12:0] RECIP_HOUR = 13'd4661;      // 2^20 / 225
  localparam logic [10:0] RECIP_MIN  = 11'd1093;      // 2^14 / 15

  function automatic logic is_leap(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // day of year at which month m (0 = january) starts
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DOY_W-1:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (m > 4'd1)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

[src/epoch_seconds_to_calendar.sv]
// a result leaves through eight register stages after its request is accepted
// throughput: one request per cycle while no result is held, eight stages in lockstep
// a stalled result freezes every stage, bubbles are not squeezed out
// reset clears all valid bits, data registers are not reset
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar
// pipelined conversion of a 32-bit second count to calendar date and time
// ---------------------------------------------------------------------------
module epoch_seconds_to_calendar
  import estc_pkg::*;
#(
  parameter int EPOCH_YEAR = 1970
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [SEC_W-1:0]   in_epoch_seconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [YEAR_W-1:0]  out_cal_year,
  output logic [MONTH_W-1:0] out_cal_month,
  output logic [DAY_W-1:0]   out_cal_day,
  output logic [HOUR_W-1:0]  out_cal_hour,
  output logic [MIN_W-1:0]   out_cal_minute,
  output logic [SECF_W-1:0]  out_cal_second,
  output logic               out_out_of_range
);

  localparam int DEPTH = 8;

  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic [DEPTH-1:0] oor_r, oor_nxt;
  logic [SEC_W-1:0] secs_r;
  logic             adv;
  logic [DAYS_W-1:0] days;
  logic [REM_W-1:0]  rem;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SECF_W-1:0]  second;
  logic               keep;

  assign adv      = !(vld_r[DEPTH-1] && out_stall);
  assign in_stall = !adv;

  always_comb begin
    vld_nxt = {vld_r[DEPTH-2:0], in_valid};
    oor_nxt = {oor_r[DEPTH-2:0], (in_epoch_seconds > MAX_VALID_COUNT)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oor_r  <= oor_nxt;
      secs_r <= in_epoch_seconds;
    end
  end

  estc_split u_split (
    .clk  (clk),
    .adv  (adv),
    .secs (secs_r),
    .days (days),
    .rem  (rem)
  );

  estc_date #(.EPOCH_YEAR(EPOCH_YEAR)) u_date (
    .clk   (clk),
    .adv   (adv),
    .days  (days),
    .year  (year),
    .month (month),
    .day   (day)
  );

  estc_tod u_tod (
    .clk    (clk),
    .adv    (adv),
    .rem    (rem),
    .hour   (hour),
    .minute (minute),
    .second (second)
  );

  // out of range requests report zero in every field
  assign keep             = !oor_r[DEPTH-1];
  assign out_valid        = vld_r[DEPTH-1];
  assign out_out_of_range = oor_r[DEPTH-1];
  assign out_cal_year     = keep ? year   : '0;
  assign out_cal_month    = keep ? month  : '0;
  assign out_cal_day      = keep ? day    : '0;
  assign out_cal_hour     = keep ? hour   : '0;
  assign out_cal_minute   = keep ? minute : '0;
  assign out_cal_second   = keep ? second : '0;

endmodule

[src/estc_split.sv]
// ---------------------------------------------------------------------------
// estc_split
// splits the second count into whole days and seconds of the day
// ---------------------------------------------------------------------------
module estc_split
  import estc_pkg::*;
(
  input  logic              clk,
  input  logic              adv,
  input  logic [SEC_W-1:0]  secs,
  output logic [DAYS_W-1:0] days,
  output logic [REM_W-1:0]  rem
);

  logic [SEC_W-2:0]  s1_secs_r;
  logic [DAYS_W-1:0] s1_days_r, s1_days_nxt;
  logic [DAYS_W-1:0] s2_days_r;
  logic [REM_W-1:0]  s2_rem_r, s2_rem_nxt;
  logic [48:0]       day_prod;
  logic [SEC_W-1:0]  day_secs;
  logic [SEC_W-1:0]  rem_full;

  always_comb begin
    day_prod    = 49'(secs[30:7]) * 49'(RECIP_DAY);
    s1_days_nxt = day_prod[48:34];
    day_secs    = 32'(s1_days_r) * 32'(SECS_PER_DAY);
    rem_full    = 32'(s1_secs_r) - day_secs;
    s2_rem_nxt  = rem_full[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_secs_r <= secs[SEC_W-2:0];
      s1_days_r <= s1_days_nxt;
      s2_days_r <= s1_days_r;
      s2_rem_r  <= s2_rem_nxt;
    end
  end

  assign days = s2_days_r;
  assign rem  = s2_rem_r;

endmodule

[src/estc_date.sv]
// ---------------------------------------------------------------------------
// estc_date
// day count to year, month and day by compare against year and month starts
// ---------------------------------------------------------------------------
module estc_date
  import estc_pkg::*;
#(
  parameter int EPOCH_YEAR = 1970
)
(
  input  logic               clk,
  input  logic               adv,
  input  logic [DAYS_W-1:0]  days,
  output logic [YEAR_W-1:0]  year,
  output logic [MONTH_W-1:0] month,
  output logic [DAY_W-1:0]   day
);

  function automatic int year_start(input int ep, input int n);
    int acc;
    acc = 0;
    for (int k = 0; k < n; k++) begin
      acc = acc + (is_leap(ep + k) ? 366 : 365);
    end
    return acc;
  endfunction

  // clamp the index to the table depth
  function automatic logic [YIDX_W-1:0] b_yidx_nxt_sel(input logic [YIDX_W-1:0] ix);
    return (ix < YIDX_W'(NUM_YEARS)) ? ix : YIDX_W'(NUM_YEARS - 1);
  endfunction

  logic [DAYS_W-1:0] ys [NUM_YEARS];
  logic              lp [NUM_YEARS];

  for (genvar gi = 0; gi < NUM_YEARS; gi++) begin : g_year
    assign ys[gi] = DAYS_W'(year_start(EPOCH_YEAR, gi));
    assign lp[gi] = is_leap(EPOCH_YEAR + gi);
  end

  logic [NUM_YEARS-1:0] a_ge_r, a_ge_nxt;
  logic [DAYS_W-1:0]    a_days_r;
  logic [YIDX_W-1:0]    b_yidx_r, b_yidx_nxt;
  logic [DAYS_W-1:0]    b_days_r;
  logic [YIDX_W-1:0]    c_yidx_r;
  logic [DOY_W-1:0]     c_doy_r, c_doy_nxt;
  logic                 c_leap_r;
  logic [11:0]          d_mge_r, d_mge_nxt;
  logic [YIDX_W-1:0]    d_yidx_r;
  logic [DOY_W-1:0]     d_doy_r;
  logic                 d_leap_r;
  logic [YEAR_W-1:0]    e_year_r, e_year_nxt;
  logic [MONTH_W-1:0]   e_month_r;
  logic [MONTH_W-1:0]   mi;
  logic [DAY_W-1:0]     e_day_r, e_day_nxt;
  logic [DAYS_W-1:0]    doy_full;
  logic [DOY_W-1:0]     doy_in_m;

  always_comb begin
    // bit 0 is always set, so the count of set bits is the year index plus one
    for (int i = 0; i < NUM_YEARS; i++) begin
      a_ge_nxt[i] = (days >= ys[i]);
    end
    b_yidx_nxt = YIDX_W'($countones(a_ge_r) - 1);
    doy_full   = b_days_r - ys[b_yidx_nxt_sel(b_yidx_r)];
    c_doy_nxt  = doy_full[DOY_W-1:0];
    for (int j = 0; j < 12; j++) begin
      d_mge_nxt[j] = (c_doy_r >= month_start(MONTH_W'(j), c_leap_r));
    end
    mi         = MONTH_W'($countones(d_mge_r) - 1);
    doy_in_m   = d_doy_r - month_start(mi, d_leap_r);
    e_day_nxt  = DAY_W'(doy_in_m + 9'd1);
    e_year_nxt = YEAR_W'(EPOCH_YEAR + int'(d_yidx_r));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ge_r    <= a_ge_nxt;
      a_days_r  <= days;
      b_yidx_r  <= b_yidx_nxt;
      b_days_r  <= a_days_r;
      c_yidx_r  <= b_yidx_r;
      c_doy_r   <= c_doy_nxt;
      c_leap_r  <= lp[b_yidx_nxt_sel(b_yidx_r)];
      d_mge_r   <= d_mge_nxt;
      d_yidx_r  <= c_yidx_r;
      d_doy_r   <= c_doy_r;
      d_leap_r  <= c_leap_r;
      e_year_r  <= e_year_nxt;
      e_month_r <= MONTH_W'(mi + 4'd1);
      e_day_r   <= e_day_nxt;
    end
  end

  assign year  = e_year_r;
  assign month = e_month_r;
  assign day   = e_day_r;

endmodule

[src/estc_tod.sv]
// ---------------------------------------------------------------------------
// estc_tod
// seconds of the day to hour, minute and second
// ---------------------------------------------------------------------------
module estc_tod
  import estc_pkg::*;
(
  input  logic              clk,
  input  logic              adv,
  input  logic [REM_W-1:0]  rem,
  output logic [HOUR_W-1:0] hour,
  output logic [MIN_W-1:0]  minute,
  output logic [SECF_W-1:0] second
);

  logic [REM_W-1:0]  a_rem_r;
  logic [REM_W-1:0]  b_rem_r;
  logic [HOUR_W-1:0] b_hour_r, b_hour_nxt;
  logic [RS_W-1:0]   c_rs_r, c_rs_nxt;
  logic [HOUR_W-1:0] c_hour_r;
  logic [RS_W-1:0]   d_rs_r;
  logic [HOUR_W-1:0] d_hour_r;
  logic [MIN_W-1:0]  d_min_r, d_min_nxt;
  logic [HOUR_W-1:0] e_hour_r;
  logic [MIN_W-1:0]  e_min_r;
  logic [SECF_W-1:0] e_sec_r, e_sec_nxt;
  logic [25:0]       hour_prod;
  logic [REM_W-1:0]  hour_secs;
  logic [REM_W-1:0]  rs_full;
  logic [20:0]       min_prod;
  logic [RS_W-1:0]   min_secs;
  logic [RS_W-1:0]   sec_full;

  always_comb begin
    hour_prod  = 26'(a_rem_r[16:4]) * 26'(RECIP_HOUR);
    b_hour_nxt = hour_prod[24:20];
    hour_secs  = REM_W'(b_hour_r) * REM_W'(SECS_PER_HOUR);
    rs_full    = b_rem_r - hour_secs;
    c_rs_nxt   = rs_full[RS_W-1:0];
    min_prod   = 21'(c_rs_r[11:2]) * 21'(RECIP_MIN);
    d_min_nxt  = min_prod[19:14];
    min_secs   = RS_W'(d_min_r) * RS_W'(SECS_PER_MIN);
    sec_full   = d_rs_r - min_secs;
    e_sec_nxt  = sec_full[SECF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rem_r  <= rem;
      b_rem_r  <= a_rem_r;
      b_hour_r <= b_hour_nxt;
      c_rs_r   <= c_rs_nxt;
      c_hour_r <= b_hour_r;
      d_rs_r   <= c_rs_r;
      d_hour_r <= c_hour_r;
      d_min_r  <= d_min_nxt;
      e_hour_r <= d_hour_r;
      e_min_r  <= d_min_r;
      e_sec_r  <= e_sec_nxt;
    end
  end

  assign hour   = e_hour_r;
  assign minute = e_min_r;
  assign second = e_sec_r;

endmodule

[src/estc_checker.sv]
// ---------------------------------------------------------------------------
// estc_checker
// port level checks for the epoch seconds to calendar converter
// ---------------------------------------------------------------------------
module estc_checker
  import estc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [YEAR_W-1:0]  out_cal_year,
  input logic [MONTH_W-1:0] out_cal_month,
  input logic [DAY_W-1:0]   out_cal_day,
  input logic [HOUR_W-1:0]  out_cal_hour,
  input logic               out_out_of_range
);

  // input side only backs up behind a held result
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to held result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_cal_year)
      && $stable(out_cal_day) && $stable(out_out_of_range)))
    else $error("stalled result changed");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_cal_year == '0 && out_cal_month == '0
      && out_cal_day == '0 && out_cal_hour == '0))
    else $error("out of range result has nonzero fields");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_out_of_range) |-> (out_cal_month >= 4'd1
      && out_cal_month <= 4'd12 && out_cal_day >= 5'd1 && out_cal_hour <= 5'd23))
    else $error("date field out of range");

endmodule

bind epoch_seconds_to_calendar estc_checker u_estc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_cal_year     (out_cal_year),
  .out_cal_month    (out_cal_month),
  .out_cal_day      (out_cal_day),
  .out_cal_hour     (out_cal_hour),
  .out_out_of_range (out_out_of_range)
);
